@@ hw/rtl/header_length_frame_parser_core_assert.svh @@
// Assertion macros shared by the header/length frame parser RTL.
`ifndef HEADER_LENGTH_FRAME_PARSER_CORE_ASSERT_SVH
`define HEADER_LENGTH_FRAME_PARSER_CORE_ASSERT_SVH

// Checked on every clock edge, reset included.
`define HLFP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while the active-low reset is released.
`define HLFP_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

@@ hw/rtl/hlfp_pkg.sv @@
// Package with types and constants for the header/length frame parser.
package hlfp_pkg;

    // Parser mode.
    typedef enum logic [1:0] {
        MODE_HUNT = 2'd0,
        MODE_HEAD = 2'd1,
        MODE_BODY = 2'd2
    } parse_mode_t;

    // One output word.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic [8:0] byte_position;
        logic       frame_end;
        logic       frame_good;
    } result_t;

    // Configuration register indexes.
    localparam logic [7:0] CFG_FIRST_HDR  = 8'd0;
    localparam logic [7:0] CFG_SECOND_HDR = 8'd1;
    localparam logic [7:0] CFG_OVERHEAD   = 8'd2;
    localparam logic [7:0] CFG_CSUM_EN    = 8'd3;

    // Configuration reset values.
    localparam logic [7:0] FIRST_HDR_RST  = 8'd255;
    localparam logic [7:0] SECOND_HDR_RST = 8'd85;
    localparam logic [4:0] OVERHEAD_RST   = 5'd7;
    localparam logic       CSUM_EN_RST    = 1'b1;

    // Frame layout.
    localparam logic [8:0] LEN_POS       = 9'd4;
    localparam logic [8:0] TRAILER_BYTES = 9'd2;
    localparam logic [4:0] OVH_MIN       = 5'd7;
    localparam logic [4:0] OVH_MAX       = 5'd16;

    // Output queue; the depth must be a power of two and at least four.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

@@ hw/rtl/header_length_frame_parser_core.sv @@
// Header/length framed byte-stream parser with a 16-bit additive trailer check.
//
// Bytes enter on the s_ channel (s_rx_byte) with valid/ready. The parser hunts
// for the two-byte header, takes the payload length at frame position 4 and
// passes every frame byte out on the m_ channel with its position. The last
// byte of a frame carries frame_end; frame_good is set when checking is off
// or the 16-bit sum of the non-trailer bytes equals the big-endian trailer.
// Configuration registers are written through the cfg_ channel, which is
// always ready; index 0 first header byte, 1 second header byte, 2 frame
// overhead, 3 checksum enable. Other indexes are ignored.
// Each accepted byte is handled in the cycle it is accepted and its output
// words are registered into the output queue. One byte is taken every cycle;
// the header lock produces two words, which a four-entry output queue
// absorbs, so the input stalls only when the queue holds more than two words.
// When the receiver stalls, words wait in the queue and s_ready drops once
// fewer than two entries are free. Synchronous active-low reset returns the
// parser to header hunting, empties the queue and restores the register
// defaults.
`include "header_length_frame_parser_core_assert.svh"

module header_length_frame_parser_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic [8:0] m_byte_position,
    output logic       m_frame_end,
    output logic       m_frame_good,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int PTR_W = hlfp_pkg::FIFO_PTR_W;
    localparam int CNT_W = hlfp_pkg::FIFO_CNT_W;

    // Configuration registers.
    logic [7:0] first_hdr_reg;
    logic [7:0] second_hdr_reg;
    logic [4:0] overhead_reg;
    logic       csum_en_reg;

    // Parser state.
    hlfp_pkg::parse_mode_t mode_reg, mode_next;
    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  total_reg, total_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  trail_reg, trail_next;

    // Output queue.
    hlfp_pkg::result_t fifo_mem [hlfp_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_p1;
    logic [CNT_W-1:0] count_reg, count_next;

    // Per-word decode.
    logic              in_accept;
    logic              out_pop;
    logic [4:0]        ovh_clamped;
    logic [8:0]        len_new;
    logic [8:0]        total_cur;
    logic [8:0]        trailer_pos;
    logic              in_sum;
    logic              at_trailer_high;
    logic              body_end;
    logic              sum_good;
    logic [1:0]        push_cnt;
    hlfp_pkg::result_t res0, res1;

    assign in_accept = s_valid && s_ready;
    assign out_pop   = m_valid && m_ready;
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_hdr_reg  <= hlfp_pkg::FIRST_HDR_RST;
            second_hdr_reg <= hlfp_pkg::SECOND_HDR_RST;
            overhead_reg   <= hlfp_pkg::OVERHEAD_RST;
            csum_en_reg    <= hlfp_pkg::CSUM_EN_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hlfp_pkg::CFG_FIRST_HDR:  first_hdr_reg  <= cfg_data;
                hlfp_pkg::CFG_SECOND_HDR: second_hdr_reg <= cfg_data;
                hlfp_pkg::CFG_OVERHEAD:   overhead_reg   <= cfg_data[4:0];
                hlfp_pkg::CFG_CSUM_EN:    csum_en_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Frame position decode: length, checksum span, trailer and end.
    always_comb begin
        if (overhead_reg < hlfp_pkg::OVH_MIN) begin
            ovh_clamped = hlfp_pkg::OVH_MIN;
        end else if (overhead_reg > hlfp_pkg::OVH_MAX) begin
            ovh_clamped = hlfp_pkg::OVH_MAX;
        end else begin
            ovh_clamped = overhead_reg;
        end
        len_new         = {1'b0, s_rx_byte} + {4'b0, ovh_clamped};
        total_cur       = (pos_reg == hlfp_pkg::LEN_POS) ? len_new : total_reg;
        trailer_pos     = total_cur - hlfp_pkg::TRAILER_BYTES;
        in_sum          = (pos_reg <= hlfp_pkg::LEN_POS) || (pos_reg < trailer_pos);
        at_trailer_high = !in_sum && (pos_reg == trailer_pos);
        body_end        = !in_sum && !at_trailer_high;
        sum_good        = !csum_en_reg || (sum_reg == {trail_reg, s_rx_byte});
    end

    // Next parser mode.
    always_comb begin
        mode_next = mode_reg;
        if (in_accept) begin
            case (mode_reg)
                hlfp_pkg::MODE_HUNT: begin
                    if (s_rx_byte == first_hdr_reg) begin
                        mode_next = hlfp_pkg::MODE_HEAD;
                    end
                end
                hlfp_pkg::MODE_HEAD: begin
                    if (s_rx_byte == second_hdr_reg) begin
                        mode_next = hlfp_pkg::MODE_BODY;
                    end else if (s_rx_byte == first_hdr_reg) begin
                        mode_next = hlfp_pkg::MODE_HEAD;
                    end else begin
                        mode_next = hlfp_pkg::MODE_HUNT;
                    end
                end
                hlfp_pkg::MODE_BODY: begin
                    if (body_end) begin
                        mode_next = hlfp_pkg::MODE_HUNT;
                    end
                end
                default: mode_next = hlfp_pkg::MODE_HUNT;
            endcase
        end
    end

    // Frame counters, running sum and output words.
    always_comb begin
        pos_next   = pos_reg;
        total_next = total_reg;
        sum_next   = sum_reg;
        trail_next = trail_reg;
        push_cnt   = 2'd0;
        res0       = '{frame_byte: s_rx_byte, byte_position: pos_reg,
                       frame_end: 1'b0, frame_good: 1'b0};
        res1       = '{frame_byte: s_rx_byte, byte_position: 9'd1,
                       frame_end: 1'b0, frame_good: 1'b0};
        if (in_accept) begin
            case (mode_reg)
                hlfp_pkg::MODE_HUNT: begin
                    if (s_rx_byte == first_hdr_reg) begin
                        trail_next = s_rx_byte;
                    end
                end
                hlfp_pkg::MODE_HEAD: begin
                    if (s_rx_byte == second_hdr_reg) begin
                        // Header locked: emit both header bytes.
                        res0       = '{frame_byte: trail_reg, byte_position: 9'd0,
                                       frame_end: 1'b0, frame_good: 1'b0};
                        push_cnt   = 2'd2;
                        pos_next   = 9'd2;
                        total_next = 9'd0;
                        sum_next   = {8'b0, trail_reg} + {8'b0, s_rx_byte};
                        trail_next = 8'd0;
                    end else if (s_rx_byte == first_hdr_reg) begin
                        trail_next = s_rx_byte;
                    end else begin
                        pos_next   = 9'd0;
                        total_next = 9'd0;
                        sum_next   = 16'd0;
                        trail_next = 8'd0;
                    end
                end
                hlfp_pkg::MODE_BODY: begin
                    res0.frame_end  = body_end;
                    res0.frame_good = body_end && sum_good;
                    push_cnt        = 2'd1;
                    if (pos_reg == hlfp_pkg::LEN_POS) begin
                        total_next = len_new;
                    end
                    if (in_sum) begin
                        sum_next = sum_reg + {8'b0, s_rx_byte};
                    end
                    if (at_trailer_high) begin
                        trail_next = s_rx_byte;
                    end
                    if (body_end) begin
                        pos_next   = 9'd0;
                        total_next = 9'd0;
                        sum_next   = 16'd0;
                        trail_next = 8'd0;
                    end else begin
                        pos_next = pos_reg + 9'd1;
                    end
                end
                default: begin
                    pos_next   = 9'd0;
                    total_next = 9'd0;
                    sum_next   = 16'd0;
                    trail_next = 8'd0;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= hlfp_pkg::MODE_HUNT;
            pos_reg   <= 9'd0;
            total_reg <= 9'd0;
            sum_reg   <= 16'd0;
            trail_reg <= 8'd0;
        end else begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            sum_reg   <= sum_next;
            trail_reg <= trail_next;
        end
    end

    // Output queue bookkeeping.
    assign wr_ptr_p1  = wr_ptr_reg + PTR_W'(1);
    assign count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(out_pop);
    assign s_ready    = (count_reg <= CNT_W'(hlfp_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            if (out_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Queue storage: up to two words written per accepted byte.
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2) begin
            fifo_mem[wr_ptr_p1] <= res1;
        end
    end

    // Result channel driven from the queue head.
    assign m_valid         = (count_reg != '0);
    assign m_frame_byte    = fifo_mem[rd_ptr_reg].frame_byte;
    assign m_byte_position = fifo_mem[rd_ptr_reg].byte_position;
    assign m_frame_end     = fifo_mem[rd_ptr_reg].frame_end;
    assign m_frame_good    = fifo_mem[rd_ptr_reg].frame_good;

    // Checks on queue occupancy and frame sequencing.
    `HLFP_ASSERT_ALWAYS(a_reset_empties_queue, aclk, !aresetn |=> (count_reg == '0), "queue not empty after reset")
    `HLFP_ASSERT_RST(a_queue_bound, aclk, aresetn, count_reg <= CNT_W'(hlfp_pkg::FIFO_DEPTH), "queue overflow")
    `HLFP_ASSERT_RST(a_body_pos, aclk, aresetn, (mode_reg == hlfp_pkg::MODE_BODY) |-> (pos_reg >= 9'd2), "frame body position below two")
    `HLFP_ASSERT_RST(a_lock, aclk, aresetn, (in_accept && (mode_reg == hlfp_pkg::MODE_HEAD) && (s_rx_byte == second_hdr_reg)) |=> ((mode_reg == hlfp_pkg::MODE_BODY) && (pos_reg == 9'd2)), "header lock did not enter frame body")
    `HLFP_ASSERT_RST(a_end_hunt, aclk, aresetn, (in_accept && (mode_reg == hlfp_pkg::MODE_BODY) && body_end) |=> ((mode_reg == hlfp_pkg::MODE_HUNT) && (sum_reg == 16'd0)), "frame end did not return to hunting")

endmodule
